### hw/rtl/dgl_pkg.sv
package dgl_pkg;

    localparam logic [31:0] COUNT_MAX_DEF = 32'd65535;
    localparam int          QLEVELS_DEF   = 256;

    localparam int SUM_W  = 37;   // sum of nine 33-bit products
    localparam int QUOT_W = 32;
    localparam int NUM_W  = 64;

    localparam logic [1:0] ALLELE_REF = 2'd0;
    localparam logic [1:0] ALLELE_ALT = 2'd1;

    localparam logic CFG_MIX   = 1'b0;
    localparam logic CFG_FLOOR = 1'b1;

    localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;
    localparam logic [31:0] RATIO_Q32 = 32'd3411613790;
    // 31*ln2 at Q.56: (31 << 24) * ln2
    localparam logic [63:0] LOG_OFF = 64'(64'd31 << 24) * 64'(LN2_Q32);

    typedef logic [255:0][31:0] t_qtab;

    // Phred error table: entry q = 10^(-q/10) in Q1.31
    function automatic t_qtab build_qtab();
        t_qtab       t;
        logic [63:0] acc;
        logic [63:0] rhi;
        logic [63:0] rlo;
        acc  = 64'd1 << 47;
        rhi  = 64'(RATIO_Q32 >> 16);
        rlo  = 64'(RATIO_Q32 & 32'hFFFF);
        t[0] = ONE_Q31;
        for (int q = 1; q < 256; q++) begin
            acc  = (acc * rhi + ((acc * rlo + 64'h8000) >> 16) + 64'h8000) >> 16;
            t[q] = 32'((acc + 64'h8000) >> 16);
        end
        return t;
    endfunction

    localparam t_qtab QTAB = build_qtab();

endpackage

### hw/rtl/droplet_pileup_genotype_likelihood_top.sv
// Doublet genotype likelihood engine for one site and droplet. Reads come in one item at a
// time (allele, Phred quality); ref and alt reads rescale nine genotype-pair likelihoods at
// the mixing fraction and add ln(sum) to a Q20.20 log normalizer, other alleles are only
// counted. An item with tlast closes the set: likelihoods are floored, renormalized, and nine
// result items (pair 0..8, tlast on pair 8) are sent, after which the set state clears.
// All arithmetic runs on one shared 32x32 multiplier and one bit-serial divider under a
// sequencer, and the input is not ready while an item is worked. A ref/alt read runs nine
// rounds of multiplies, nine divisions (the divider is the bottleneck), a leading-one
// search and the log squaring steps, plus sequencing states. A closing item adds a floor
// pass, the nine divisions and the log steps, plus the nine result transfers. Counter-only
// items leave the sequencer idle. Configuration writes land at once and must come only
// while idle.
module droplet_pileup_genotype_likelihood_top #(
    parameter logic [31:0] COUNT_MAX      = dgl_pkg::COUNT_MAX_DEF,
    parameter int          QUALITY_LEVELS = dgl_pkg::QLEVELS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config: index 0 mixing_fraction, 1 likelihood_floor
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // allele[1:0], base_quality[9:2], zero pad
    input  logic         s_axis_tuser,   // has_read
    input  logic         s_axis_tlast,   // end_of_set
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // genotype_pair[3:0], likelihood[35:4], log_normalizer[75:36], ref_reads[91:76],
    // alt_reads[107:92], total_reads[123:108], zero pad
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tlast    // last_of_run
);
    localparam int SW = dgl_pkg::SUM_W;
    localparam logic [15:0] CNT_CAP = (COUNT_MAX < 32'd65535) ? 16'(COUNT_MAX) : 16'hFFFF;
    localparam logic [8:0]  QL      = 9'(QUALITY_LEVELS);
    localparam logic [7:0]  QMAX    = 8'(QUALITY_LEVELS - 1);
    localparam logic signed [19:0] ONE  = 20'sd131072;
    localparam logic signed [19:0] HALF = 20'sd65536;

    // sequencer states
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_TERM_MUL = 5'd1;
    localparam logic [4:0] S_TERM_ADD = 5'd2;
    localparam logic [4:0] S_G_LO     = 5'd3;
    localparam logic [4:0] S_G_HI     = 5'd4;
    localparam logic [4:0] S_G_ACC    = 5'd5;
    localparam logic [4:0] S_FLOOR    = 5'd6;
    localparam logic [4:0] S_NORM_CHK = 5'd7;
    localparam logic [4:0] S_DIV_GO   = 5'd8;
    localparam logic [4:0] S_DIV_WAIT = 5'd9;
    localparam logic [4:0] S_LOG_NORM = 5'd10;
    localparam logic [4:0] S_LOG_SQ   = 5'd11;
    localparam logic [4:0] S_LOG_SQ2  = 5'd12;
    localparam logic [4:0] S_LOG_MUL  = 5'd13;
    localparam logic [4:0] S_LOG_ADD  = 5'd14;
    localparam logic [4:0] S_AFTER    = 5'd15;
    localparam logic [4:0] S_OUT      = 5'd16;

    logic [4:0]         r_state;
    logic [3:0]         r_k;
    logic [16:0]        r_mix;
    logic [31:0]        r_floor;
    logic [31:0]        r_lk [9];     // pair likelihoods, Q1.31
    logic [32:0]        r_g  [9];     // unnormalized products
    logic [SW-1:0]      r_sum;
    logic signed [39:0] r_log;
    logic [15:0]        r_ref;
    logic [15:0]        r_alt;
    logic [15:0]        r_tot;
    logic [1:0]         r_al;
    logic [31:0]        r_err;
    logic               r_close;
    logic               r_fin;
    logic [47:0]        r_term;
    logic [63:0]        r_plo;
    logic [63:0]        r_prod;
    logic [SW-1:0]      r_y;
    logic [31:0]        r_ysq;
    logic [5:0]         r_pexp;
    logic [23:0]        r_frac;
    logic [4:0]         r_i;

    logic [1:0]         n_allele;
    logic [7:0]         n_q;
    logic [7:0]         n_qeff;
    logic               n_in_acc;
    logic               n_out_acc;
    logic [16:0]        n_alpha;
    logic signed [19:0] n_a;
    logic signed [19:0] n_f;
    logic signed [19:0] n_share;
    logic               n_neg;
    logic [17:0]        n_mag;
    logic [31:0]        n_mat;
    logic [30:0]        n_quarter;
    logic [63:0]        n_pm;
    logic [63:0]        n_t1;
    logic [63:0]        n_full;
    logic [63:0]        n_round;
    logic [32:0]        n_gval;
    logic [31:0]        n_fl;
    logic [31:0]        n_fval;
    logic [63:0]        n_num;
    logic [31:0]        n_ma;
    logic [31:0]        n_mb;
    logic [32:0]        n_sq;
    logic [63:0]        n_dmag;
    logic signed [40:0] n_v;
    logic signed [40:0] n_lsum;
    logic signed [39:0] n_lsat;
    logic               n_div_done;
    logic [31:0]        n_quot;

    assign n_allele  = s_axis_tdata[1:0];
    assign n_q       = s_axis_tdata[9:2];
    assign n_qeff    = ({1'b0, n_q} >= QL) ? QMAX : n_q;
    assign n_in_acc  = s_axis_tvalid && s_axis_tready;
    assign n_out_acc = m_axis_tvalid && m_axis_tready;

    // pair share of the read allele, Q1.17 in a signed word, stays in 0..1 as the mix is capped at one half
    assign n_alpha = (r_mix > 17'd65536) ? 17'd65536 : r_mix;
    assign n_a     = $signed({3'b000, n_alpha});
    always_comb begin
        case (r_k)
            4'd0:    n_f = ONE;
            4'd1:    n_f = ONE - n_a;
            4'd2:    n_f = ONE - (n_a <<< 1);
            4'd3:    n_f = HALF + n_a;
            4'd4:    n_f = HALF;
            4'd5:    n_f = HALF - n_a;
            4'd6:    n_f = n_a <<< 1;
            4'd7:    n_f = n_a;
            default: n_f = 20'sd0;
        endcase
    end
    assign n_share   = (r_al == dgl_pkg::ALLELE_REF) ? n_f : (ONE - n_f);
    assign n_neg     = n_share[19];
    assign n_mag     = n_neg ? 18'(-n_share) : n_share[17:0];
    assign n_mat     = dgl_pkg::ONE_Q31 - r_err;
    assign n_quarter = 31'(({1'b0, r_err} + 33'd2) >> 2);

    // term = ((mat*share + half) >> 17) + quarter, modulo 2^64
    assign n_pm = n_neg ? (64'd0 - r_prod) : r_prod;
    assign n_t1 = (n_pm + 64'h1_0000) >> 17;

    // g = (lk*term + 2^30) >> 31, product kept modulo 2^64
    assign n_full  = r_plo + {r_prod[31:0], 32'd0};
    assign n_round = n_full + 64'h4000_0000;
    assign n_gval  = n_round[63:31];

    assign n_fl   = (r_floor > dgl_pkg::ONE_Q31) ? dgl_pkg::ONE_Q31 : r_floor;
    assign n_fval = (r_lk[r_k] < n_fl) ? n_fl : r_lk[r_k];

    assign n_num = {r_g[r_k], 31'd0} + 64'(r_sum >> 1);

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_TERM_MUL: begin n_ma = n_mat;      n_mb = 32'(n_mag);         end
            S_G_LO:     begin n_ma = r_lk[r_k];  n_mb = r_term[31:0];       end
            S_G_HI:     begin n_ma = r_lk[r_k];  n_mb = 32'(r_term[47:32]); end
            S_LOG_SQ:   begin n_ma = r_ysq;      n_mb = r_ysq;              end
            S_LOG_MUL:  begin n_ma = {2'b00, r_pexp, r_frac}; n_mb = dgl_pkg::LN2_Q32; end
            default:    begin n_ma = r_ysq;      n_mb = r_ysq;              end
        endcase
    end

    assign n_sq = r_prod[63:31];

    // ln(sum) to Q20.20, half away from zero, then saturating add
    always_comb begin
        if (r_prod >= dgl_pkg::LOG_OFF) begin
            n_dmag = (r_prod - dgl_pkg::LOG_OFF + 64'h8_0000_0000) >> 36;
            n_v    = $signed(41'(n_dmag));
        end else begin
            n_dmag = (dgl_pkg::LOG_OFF - r_prod + 64'h8_0000_0000) >> 36;
            n_v    = -$signed(41'(n_dmag));
        end
        n_lsum = 41'(r_log) + n_v;
        if (n_lsum > 41'sh7F_FFFF_FFFF)
            n_lsat = 40'sh7F_FFFF_FFFF;
        else if (n_lsum < -41'sh80_0000_0000)
            n_lsat = -40'sh80_0000_0000;
        else
            n_lsat = n_lsum[39:0];
    end

    dgl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV_GO),
        .i_num   (n_num),
        .i_den   (r_sum),
        .o_done  (n_div_done),
        .o_quot  (n_quot)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= n_ma * n_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_mix   <= 17'd32768;
            r_floor <= 32'd2147;
            for (int j = 0; j < 9; j++) r_lk[j] <= dgl_pkg::ONE_Q31;
            r_log   <= '0;
            r_ref   <= '0;
            r_alt   <= '0;
            r_tot   <= '0;
            r_close <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == dgl_pkg::CFG_MIX) r_mix <= i_cfg_data[16:0];
                else                                r_floor <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        r_al    <= n_allele;
                        r_err   <= dgl_pkg::QTAB[n_qeff];
                        r_close <= s_axis_tlast;
                        r_k     <= '0;
                        r_sum   <= '0;
                        if (s_axis_tuser) begin
                            if (r_tot < CNT_CAP) r_tot <= r_tot + 16'd1;
                            if (n_allele == dgl_pkg::ALLELE_REF && r_ref < CNT_CAP)
                                r_ref <= r_ref + 16'd1;
                            if (n_allele == dgl_pkg::ALLELE_ALT && r_alt < CNT_CAP)
                                r_alt <= r_alt + 16'd1;
                        end
                        if (s_axis_tuser && !n_allele[1]) begin
                            r_fin   <= 1'b0;
                            r_state <= S_TERM_MUL;
                        end else if (s_axis_tlast) begin
                            r_fin   <= 1'b1;
                            r_state <= S_FLOOR;
                        end
                    end
                end
                S_TERM_MUL: r_state <= S_TERM_ADD;
                S_TERM_ADD: begin
                    r_term  <= 48'(n_t1) + 48'(n_quarter);
                    r_state <= S_G_LO;
                end
                S_G_LO: r_state <= S_G_HI;
                S_G_HI: begin
                    r_plo   <= r_prod;
                    r_state <= S_G_ACC;
                end
                S_G_ACC: begin
                    r_g[r_k] <= n_gval;
                    r_sum    <= r_sum + SW'(n_gval);
                    if (r_k == 4'd8) begin
                        r_state <= S_NORM_CHK;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_TERM_MUL;
                    end
                end
                S_FLOOR: begin
                    r_g[r_k] <= {1'b0, n_fval};
                    r_sum    <= r_sum + SW'(n_fval);
                    if (r_k == 4'd8) r_state <= S_NORM_CHK;
                    else             r_k <= r_k + 4'd1;
                end
                S_NORM_CHK: begin
                    r_k <= '0;
                    // zero sum: likelihoods and log stay as they are
                    r_state <= (r_sum == '0) ? S_AFTER : S_DIV_GO;
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (n_div_done) begin
                        r_lk[r_k] <= n_quot;
                        if (r_k == 4'd8) begin
                            r_y     <= r_sum;
                            r_pexp  <= 6'(SW - 1);
                            r_state <= S_LOG_NORM;
                        end else begin
                            r_k     <= r_k + 4'd1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_LOG_NORM: begin
                    // leading-one search, one bit per cycle
                    if (r_y[SW-1]) begin
                        r_ysq   <= r_y[SW-1:SW-32];
                        r_i     <= 5'd23;
                        r_frac  <= '0;
                        r_state <= S_LOG_SQ;
                    end else begin
                        r_y    <= {r_y[SW-2:0], 1'b0};
                        r_pexp <= r_pexp - 6'd1;
                    end
                end
                S_LOG_SQ: r_state <= S_LOG_SQ2;
                S_LOG_SQ2: begin
                    if (n_sq[32]) begin
                        r_ysq       <= n_sq[32:1];
                        r_frac[r_i] <= 1'b1;
                    end else begin
                        r_ysq <= n_sq[31:0];
                    end
                    if (r_i == 5'd0) begin
                        r_state <= S_LOG_MUL;
                    end else begin
                        r_i     <= r_i - 5'd1;
                        r_state <= S_LOG_SQ;
                    end
                end
                S_LOG_MUL: r_state <= S_LOG_ADD;
                S_LOG_ADD: begin
                    r_log   <= n_lsat;
                    r_state <= S_AFTER;
                end
                S_AFTER: begin
                    r_k   <= '0;
                    r_sum <= '0;
                    if (r_fin) begin
                        r_state <= S_OUT;
                    end else if (r_close) begin
                        r_fin   <= 1'b1;
                        r_state <= S_FLOOR;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (n_out_acc) begin
                        if (r_k == 4'd8) begin
                            for (int j = 0; j < 9; j++) r_lk[j] <= dgl_pkg::ONE_Q31;
                            r_log   <= '0;
                            r_ref   <= '0;
                            r_alt   <= '0;
                            r_tot   <= '0;
                            r_k     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 4'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tlast  = (r_k == 4'd8);
    assign m_axis_tdata  = {4'd0, r_tot, r_alt, r_ref, r_log, r_lk[r_k], r_k};

    // input and output sides never open at once in this sequencer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while results pending");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[3:0] == 4'd8))
        else $error("last result is not pair 8");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
        (r_ref == 16'd0 && r_alt == 16'd0 && r_tot == 16'd0 && r_log == 40'sd0))
        else $error("set state not cleared after run");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside wait state");

endmodule

### hw/rtl/dgl_div.sv
// Restoring divider, one quotient bit per cycle. Quotient must fit QUOT_W bits.
module dgl_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dgl_pkg::NUM_W-1:0]  i_num,
    input  logic [dgl_pkg::SUM_W-1:0]  i_den,   // held stable while busy
    output logic                       o_done,
    output logic [dgl_pkg::QUOT_W-1:0] o_quot
);
    localparam int SW = dgl_pkg::SUM_W;
    localparam int QW = dgl_pkg::QUOT_W;

    logic          r_busy;
    logic          r_done;
    logic [5:0]    r_cnt;
    logic [SW-1:0] r_rem;
    logic [QW-1:0] r_lo;
    logic [QW-1:0] r_q;
    logic [SW:0]   n_trial;
    logic          n_ge;

    assign n_trial = {r_rem, r_lo[QW-1]};
    assign n_ge    = n_trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= SW'(i_num[dgl_pkg::NUM_W-1:QW]);
                r_lo   <= i_num[QW-1:0];
                r_cnt  <= 6'(QW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_ge ? SW'(n_trial - {1'b0, i_den}) : n_trial[SW-1:0];
                r_q   <= {r_q[QW-2:0], n_ge};
                r_lo  <= {r_lo[QW-2:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
